// ----- design/ilws_pkg.sv -----
// Shared types and constants for the indexed list with sort.
package ilws_pkg;

  localparam int unsigned ACT_W       = 3;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned CNT_OUT_W   = 7;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_SORT   = 3'd4
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RDWAIT  = 9'b000000010,
    S_SH_RD   = 9'b000000100,
    S_SH_WR   = 9'b000001000,
    S_SO_LDV  = 9'b000010000,
    S_SO_GETV = 9'b000100000,
    S_SO_RDP  = 9'b001000000,
    S_SO_CMP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

endpackage

// ----- design/ilws_cmp.sv -----
// Shared element comparator: signed or unsigned greater-than.
module ilws_cmp
  import ilws_pkg::*;
#(
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic [ELEM_BITS-1:0] a_i,
  input  logic [ELEM_BITS-1:0] b_i,
  input  logic                 signed_i,
  output logic                 after_o
);

  logic [ELEM_BITS-1:0] flip;
  logic [ELEM_BITS-1:0] a_k;
  logic [ELEM_BITS-1:0] b_k;

  always_comb begin
    flip = '0;
    flip[ELEM_BITS-1] = signed_i;
  end

  assign a_k     = a_i ^ flip;
  assign b_k     = b_i ^ flip;
  assign after_o = (a_k > b_k);

endmodule

// ----- design/indexed_list_with_sort.sv -----
// Top level of the indexed list with sort.
//
// Packed list of up to CAPACITY elements in a single-port-write, registered-read
// RAM, with a live count. One transaction on s_axis carries one command; the
// command sits in s_axis_tuser (append, read, write, remove, sort range) and its
// operands in s_axis_tdata. Each command returns one transaction on m_axis with
// status, read data and the count after the command.
// One command is in flight at a time; s_axis_tready is high only while idle.
// Append, write, rejected commands and empty sort ranges go straight to the
// result; read waits on the registered read; remove shifts later elements down.
// Sort is an insertion sort on one comparator and the one RAM port; each element
// is loaded, then larger predecessors move up one place until its slot is found.
// cfg_we_i/cfg_wdata_i set the sort compare mode (0 unsigned, 1 signed); write it
// only while idle. Reset clears the count, the mode and the output valid flag;
// element contents are not cleared and there is no clearing pass.
// When m_axis_tready is low the finished result holds in the output register;
// a following command is still accepted and held at its end until the result
// is taken.
module indexed_list_with_sort
  import ilws_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] index, [11:6] range_end, [43:12] value, [47:44] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] action
  input  logic [ACT_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [33:2] read_value, [40:34] count, [47:41] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned WW = (ELEM_BITS > VAL_W) ? ELEM_BITS : VAL_W;

  logic [ELEM_BITS-1:0] mem [CAPACITY];
  logic [ELEM_BITS-1:0] rd_q;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        i_q, i_d;
  logic [AW-1:0]        j_q, j_d;
  logic [AW-1:0]        lo_q, lo_d;
  logic [AW-1:0]        hi_q, hi_d;
  logic [ELEM_BITS-1:0] v_q, v_d;
  status_e              status_q, status_d;
  logic [VAL_W-1:0]     rdval_q, rdval_d;
  logic                 cmp_signed_q;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ELEM_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  logic                 accept;
  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        end_x;
  logic [XW-1:0]        cnt_x;
  logic [WW-1:0]        val_ext;
  logic [ELEM_BITS-1:0] val_in;
  logic [WW-1:0]        rd_ext;
  logic [CW-1:0]        i_inc;
  logic                 after;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_x         = XW'(s_axis_tdata[IDX_W-1:0]);
  assign end_x         = XW'(s_axis_tdata[2*IDX_W-1:IDX_W]);
  assign cnt_x         = XW'(cnt_q);
  assign val_ext       = WW'(s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]);
  assign val_in        = val_ext[ELEM_BITS-1:0];
  assign rd_ext        = WW'(rd_q);
  assign i_inc         = i_q + CW'(1);

  ilws_cmp #(
    .ELEM_BITS(ELEM_BITS)
  ) u_cmp (
    .a_i      (rd_q),
    .b_i      (v_q),
    .signed_i (cmp_signed_q),
    .after_o  (after)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    v_d       = v_q;
    status_d  = status_q;
    rdval_d   = rdval_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = j_q;
    mem_wdata = v_q;
    mem_raddr = j_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          rdval_d  = '0;
          state_d  = S_DONE;
          case (s_axis_tuser)
            ACT_APPEND: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[AW-1:0];
                mem_wdata = val_in;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            ACT_READ: begin
              if (idx_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                mem_raddr = idx_x[AW-1:0];
                state_d   = S_RDWAIT;
              end
            end
            ACT_WRITE: begin
              if (idx_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_x[AW-1:0];
                mem_wdata = val_in;
              end
            end
            ACT_REMOVE: begin
              if (idx_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                i_d     = idx_x[CW-1:0];
                state_d = S_SH_RD;
              end
            end
            ACT_SORT: begin
              if (end_x > idx_x) begin
                if (end_x >= cnt_x) begin
                  status_d = ST_RANGE;
                end else begin
                  lo_d    = idx_x[AW-1:0];
                  hi_d    = end_x[AW-1:0];
                  i_d     = idx_x[CW-1:0] + CW'(1);
                  state_d = S_SO_LDV;
                end
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        rdval_d = rd_ext[VAL_W-1:0];
        state_d = S_DONE;
      end
      S_SH_RD: begin
        if (i_inc < cnt_q) begin
          mem_raddr = i_inc[AW-1:0];
          state_d   = S_SH_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[AW-1:0];
        mem_wdata = rd_q;
        i_d       = i_inc;
        state_d   = S_SH_RD;
      end
      S_SO_LDV: begin
        if (i_q > CW'(hi_q)) begin
          state_d = S_DONE;
        end else begin
          mem_raddr = i_q[AW-1:0];
          j_d       = i_q[AW-1:0];
          state_d   = S_SO_GETV;
        end
      end
      S_SO_GETV: begin
        v_d     = rd_q;
        state_d = S_SO_RDP;
      end
      S_SO_RDP: begin
        if (j_q > lo_q) begin
          mem_raddr = j_q - AW'(1);
          state_d   = S_SO_CMP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          mem_wdata = v_q;
          i_d       = i_inc;
          state_d   = S_SO_LDV;
        end
      end
      S_SO_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        if (after) begin
          mem_wdata = rd_q;
          j_d       = j_q - AW'(1);
          state_d   = S_SO_RDP;
        end else begin
          mem_wdata = v_q;
          i_d       = i_inc;
          state_d   = S_SO_LDV;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_TDATA_W'({CNT_OUT_W'(cnt_q), rdval_q, status_q});
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      m_valid_q    <= 1'b0;
      cmp_signed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        cmp_signed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    v_q      <= v_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- design/ilws_checker.sv -----
// Port-level checker for the indexed list with sort, with its bind.
module ilws_checker
  import ilws_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [ST_W-1:0]      st;
  logic [VAL_W-1:0]     rdv;
  logic [CNT_OUT_W-1:0] cnt;

  assign st  = m_axis_tdata[ST_W-1:0];
  assign rdv = m_axis_tdata[ST_W+VAL_W-1:ST_W];
  assign cnt = m_axis_tdata[ST_W+VAL_W+CNT_OUT_W-1:ST_W+VAL_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in flight");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st != ST_OK) |-> rdv == '0)
    else $error("read data nonzero on failed command");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_FULL) |-> 32'(cnt) == 32'(CAPACITY))
    else $error("store full reported below capacity");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(cnt) <= 32'(CAPACITY))
    else $error("count above capacity");

endmodule

bind indexed_list_with_sort ilws_checker #(
  .CAPACITY(CAPACITY)
) u_ilws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb.sv -----
// Testbench for the indexed list with sort: directed table, random traffic, predictor check.
`timescale 1ns / 100ps

module tb;
  import ilws_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned N_DIRECTED = 25;
  localparam int unsigned N_PHASES = 4;
  localparam int unsigned ITEMS_PER_PHASE = 420;
  localparam int unsigned MODE_SPAN = 140;

  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  localparam bit CMP_UNSIGNED = 1'b0;
  localparam bit CMP_SIGNED = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] range_end;
    logic [VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    status_e status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    list_cmd_t cmd;
    bit typed;
    list_result_t want;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic [ACT_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [VAL_W-1:0] list_mem [LIST_DEPTH];
  int unsigned list_len;
  bit sort_signed;

  list_result_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned big_sorts_left;
  bit grow_mode;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{ACT_READ,   6'd0,  6'd0,  32'h0000_0000}, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
    '{'{ACT_WRITE,  6'd0,  6'd0,  32'hDEAD_BEEF}, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
    '{'{ACT_REMOVE, 6'd0,  6'd0,  32'h0000_0000}, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
    '{'{ACT_SORT,   6'd0,  6'd63, 32'h0000_0000}, 1'b1, '{ST_RANGE, 32'h0, 7'd0}},
    '{'{ACT_SORT,   6'd7,  6'd7,  32'h0000_0000}, 1'b1, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_SORT,   6'd63, 6'd0,  32'h0000_0000}, 1'b1, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_RSVD5,  6'd0,  6'd0,  32'hFFFF_FFFF}, 1'b1, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_RSVD6,  6'd63, 6'd63, 32'h5555_AAAA}, 1'b1, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_RSVD7,  6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_APPEND, 6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,    32'h0, 7'd1}},
    '{'{ACT_APPEND, 6'd0,  6'd0,  32'h0000_0000}, 1'b1, '{ST_OK,    32'h0, 7'd2}},
    '{'{ACT_APPEND, 6'd0,  6'd0,  32'h8000_0000}, 1'b1, '{ST_OK,    32'h0, 7'd3}},
    '{'{ACT_APPEND, 6'd0,  6'd0,  32'h7FFF_FFFF}, 1'b1, '{ST_OK,    32'h0, 7'd4}},
    '{'{ACT_APPEND, 6'd0,  6'd0,  32'h0000_0001}, 1'b1, '{ST_OK,    32'h0, 7'd5}},
    '{'{ACT_READ,   6'd0,  6'd63, 32'h0000_0000}, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 7'd5}},
    '{'{ACT_READ,   6'd4,  6'd0,  32'hFFFF_FFFF}, 1'b1, '{ST_OK,    32'h0000_0001, 7'd5}},
    '{'{ACT_READ,   6'd5,  6'd0,  32'h0000_0000}, 1'b1, '{ST_RANGE, 32'h0, 7'd5}},
    '{'{ACT_READ,   6'd63, 6'd0,  32'h0000_0000}, 1'b1, '{ST_RANGE, 32'h0, 7'd5}},
    '{'{ACT_SORT,   6'd0,  6'd4,  32'h0000_0000}, 1'b0, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_READ,   6'd0,  6'd0,  32'h0000_0000}, 1'b0, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_READ,   6'd4,  6'd0,  32'h0000_0000}, 1'b0, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_WRITE,  6'd2,  6'd0,  32'hAAAA_5555}, 1'b0, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_REMOVE, 6'd0,  6'd0,  32'h0000_0000}, 1'b0, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_REMOVE, 6'd3,  6'd0,  32'h0000_0000}, 1'b0, '{ST_OK,    32'h0, 7'd0}},
    '{'{ACT_SORT,   6'd0,  6'd2,  32'h0000_0000}, 1'b0, '{ST_OK,    32'h0, 7'd0}}
  };

  bit phase_modes [N_PHASES] = '{CMP_SIGNED, CMP_UNSIGNED, CMP_SIGNED, CMP_UNSIGNED};
  int unsigned phase_idle [N_PHASES] = '{0, 65, 0, 11};
  int unsigned phase_stall [N_PHASES] = '{0, 0, 65, 11};

  indexed_list_with_sort dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic bit sorts_after(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    if (sort_signed) begin
      return $signed(a) > $signed(b);
    end
    return a > b;
  endfunction

  function automatic list_result_t apply_list_command(list_cmd_t c);
    list_result_t r;
    int unsigned i;
    int unsigned j;
    logic [VAL_W-1:0] v;
    r.status = ST_OK;
    r.read_value = '0;
    case (c.action)
      ACT_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = c.value;
          list_len++;
        end
      end
      ACT_READ: begin
        if (c.index >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[c.index];
      end
      ACT_WRITE: begin
        if (c.index >= list_len) r.status = ST_RANGE;
        else list_mem[c.index] = c.value;
      end
      ACT_REMOVE: begin
        if (c.index >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = c.index; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      ACT_SORT: begin
        if (c.range_end > c.index) begin
          if (c.range_end >= list_len) begin
            r.status = ST_RANGE;
          end else begin
            for (i = c.index + 1; i <= c.range_end; i++) begin
              v = list_mem[i];
              j = i;
              while (j > c.index && sorts_after(list_mem[j - 1], v)) begin
                list_mem[j] = list_mem[j - 1];
                j--;
              end
              list_mem[j] = v;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_OUT_W'(list_len);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (list_len != 0 && $urandom_range(0, 9) != 0) begin
      return IDX_W'($urandom_range(0, list_len - 1));
    end
    return IDX_W'($urandom_range(0, 63));
  endfunction

  function automatic list_cmd_t make_random_command();
    list_cmd_t c;
    int unsigned roll;
    int unsigned hi;
    logic [IDX_W-1:0] tmp;
    c.action = ACT_APPEND;
    c.index = IDX_W'($urandom);
    c.range_end = IDX_W'($urandom);
    case ($urandom_range(0, 7))
      0: c.value = '0;
      1: c.value = '1;
      2: c.value = 32'h8000_0000 + $urandom_range(0, 3);
      3: c.value = 32'h7FFF_FFFF - $urandom_range(0, 3);
      4: c.value = VAL_W'($urandom_range(0, 7));
      5: c.value = 32'hFFFF_FFF8 + $urandom_range(0, 7);
      default: c.value = $urandom;
    endcase
    roll = $urandom_range(0, 99);
    if (roll >= (grow_mode ? 93 : 90)) begin
      c.action = ACT_W'($urandom_range(0, 7));
    end else if (roll < (grow_mode ? 45 : 12)) begin
      c.action = ACT_APPEND;
    end else if (roll < (grow_mode ? 60 : 30)) begin
      c.action = ACT_READ;
      c.index = pick_index();
    end else if (roll < (grow_mode ? 70 : 42)) begin
      c.action = ACT_WRITE;
      c.index = pick_index();
    end else if (roll < (grow_mode ? 78 : 75)) begin
      c.action = ACT_REMOVE;
      c.index = pick_index();
    end else begin
      c.action = ACT_SORT;
      if (big_sorts_left != 0 && list_len > 1 && $urandom_range(0, 29) == 0) begin
        c.index = IDX_W'($urandom_range(0, 1));
        c.range_end = IDX_W'(list_len - 1);
        big_sorts_left--;
      end else begin
        c.index = pick_index();
        hi = c.index + $urandom_range(0, 9);
        c.range_end = (hi > 63) ? IDX_W'(63) : IDX_W'(hi);
        if ($urandom_range(0, 15) == 0) begin
          tmp = c.index;
          c.index = c.range_end;
          c.range_end = tmp;
        end
      end
    end
    return c;
  endfunction

  task automatic send_command(list_cmd_t c, bit typed, list_result_t want);
    list_result_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, c.value, c.range_end, c.index};
    s_axis_tuser = c.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_list_command(c);
    pending_results.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_compare_mode(bit mode);
    cfg_we_i = 1'b1;
    cfg_wdata_i = mode;
    sort_signed = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        list_result_t got;
        list_result_t want;
        got.status = status_e'(m_axis_tdata[1:0]);
        got.read_value = m_axis_tdata[33:2];
        got.count = m_axis_tdata[40:34];
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result status=%0d read=%h count=%0d", $realtime,
                     got.status, got.read_value, got.count);
          end
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.read_value !== want.read_value ||
              got.count !== want.count) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch status exp=%0d got=%0d read exp=%h got=%h count exp=%0d got=%0d",
                       $realtime, want.status, got.status, want.read_value, got.read_value,
                       want.count, got.count);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned issued;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    big_sorts_left = 24;
    grow_mode = 1'b1;
    issued = 0;
    list_len = 0;
    sort_signed = CMP_UNSIGNED;
    foreach (list_mem[i]) list_mem[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_compare_mode(CMP_UNSIGNED);
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end
    for (p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_compare_mode(phase_modes[p]);
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (issued % MODE_SPAN == MODE_SPAN - 1) grow_mode = ~grow_mode;
        send_command(make_random_command(), 1'b0, '0);
        issued++;
      end
    end
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- indexed_list_with_sort.f -----
design/ilws_pkg.sv
design/ilws_cmp.sv
design/indexed_list_with_sort.sv
design/ilws_checker.sv
test/tb.sv
